### sv/i2c_mbs_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
// No dependencies; the core and its checker refer to it by scoped names.

package i2c_mbs_pkg;

  // Command codes carried in the kind field
  typedef enum logic [2:0] {
    KIND_START    = 3'd0,
    KIND_STOP     = 3'd1,
    KIND_WRITE    = 3'd2,
    KIND_WAIT_ACK = 3'd3,
    KIND_READ_ACK = 3'd4,
    KIND_READ     = 3'd5,
    KIND_SEND_ACK = 3'd6,
    KIND_SEND_NAK = 3'd7
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_TICKS_PER_US = 2'd0;
  localparam logic [1:0] CFG_ACK_POLL_LIM = 2'd1;

  // Register widths and reset values
  localparam int unsigned CFG_W       = 10;
  localparam int unsigned DELAY_W     = 12;
  localparam int unsigned BYTE_W      = 8;
  localparam logic [CFG_W-1:0] TICKS_PER_US_RST = 10'd16;
  localparam logic [CFG_W-1:0] ACK_POLL_LIM_RST = 10'd250;

  // Bit positions in the result word
  localparam int unsigned OUT_SCL  = 0;
  localparam int unsigned OUT_SDA  = 1;
  localparam int unsigned OUT_DRV  = 2;
  localparam int unsigned OUT_BUSY = 3;
  localparam int unsigned OUT_DONE = 4;
  localparam int unsigned OUT_RX   = 5;
  localparam int unsigned OUT_FAIL = 13;

endpackage

### sv/i2c_master_bit_sequencer_core.sv
// Top level of the I2C master bit sequencer: phase machine, delay and bit
// counters, and the registered result word. Depends on i2c_mbs_pkg.

// The block takes one input word per clock tick and returns one result word
// per input word, so it sustains one word per cycle while out_tready does not
// stall the output register. Each accepted word advances the phase register,
// the delay counter, the bit counter and the shift register by one tick; the
// result is held in an output register, and a new word is taken whenever that
// register is empty or is being read in the same cycle. Line delays of 4, 2
// and 1 microseconds last 4, 2 and 1 times ticks_per_us input words (at least
// one word each). While waiting for an acknowledge, SDA is sampled once per
// word; if it is still high after more than ack_poll_limit samples, a stop
// condition is sent and ack_failed is set. Commands that arrive while busy
// are ignored. After reset both lines are driven high.

module i2c_master_bit_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] tx_byte, [8] ack_after_read, [9] sda_in
  input  logic [3:0]  in_tuser,   // [0] cmd_valid, [3:1] kind
  // Result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] scl_level, [1] sda_level, [2] sda_drive,
                                  // [3] busy_res, [4] done_res, [12:5] rx_byte,
                                  // [13] ack_failed
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_WR_SETUP, PH_WR_HIGH,
    PH_WR_LOW, PH_WA_A, PH_WA_B, PH_WA_POLL, PH_RD_LOW, PH_RD_HIGH,
    PH_AK_A, PH_AK_B
  } phase_t;

  localparam int unsigned CW = i2c_mbs_pkg::CFG_W;
  localparam int unsigned DW = i2c_mbs_pkg::DELAY_W;
  localparam int unsigned BW = i2c_mbs_pkg::BYTE_W;

  // Configuration registers
  logic [CW-1:0] tpu_r;
  logic [CW-1:0] poll_lim_r;

  // Sequencer state
  phase_t                 ph_r, ph_nxt;
  i2c_mbs_pkg::kind_t     kind_r, kind_nxt;
  logic [DW-1:0]          dly_r, dly_nxt;
  logic [3:0]             bit_cnt_r, bit_cnt_nxt;
  logic [BW-1:0]          shift_r, shift_nxt;
  logic [CW-1:0]          poll_r, poll_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic                   drv_r, drv_nxt;
  logic                   ack_sel_r, ack_sel_nxt;
  logic [BW-1:0]          rx_r, rx_nxt;
  logic                   fail_r, fail_nxt;
  logic                   done;

  // Output register
  logic                   out_valid_r;
  logic [15:0]            out_data_r;

  // Input word fields
  logic                   in_cmd;
  i2c_mbs_pkg::kind_t     in_kind;
  logic [BW-1:0]          in_tx;
  logic                   in_ack;
  logic                   in_sda;
  logic                   in_fire;

  // Delay lengths for 1, 2 and 4 microseconds
  logic [DW-1:0]          dly_1us, dly_2us, dly_4us, dly_dec;
  logic [3:0]             bit_cnt_inc;

  assign in_cmd  = in_tuser[0];
  assign in_kind = i2c_mbs_pkg::kind_t'(in_tuser[3:1]);
  assign in_tx   = in_tdata[7:0];
  assign in_ack  = in_tdata[8];
  assign in_sda  = in_tdata[9];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign dly_1us     = {2'b00, tpu_r};
  assign dly_2us     = {1'b0, tpu_r, 1'b0};
  assign dly_4us     = {tpu_r, 2'b00};
  assign dly_dec     = (dly_r != '0) ? dly_r - DW'(1) : dly_r;
  assign bit_cnt_inc = bit_cnt_r + 4'd1;

  // One tick of the sequencer
  always_comb begin
    ph_nxt      = ph_r;
    kind_nxt    = kind_r;
    dly_nxt     = dly_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    poll_nxt    = poll_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    drv_nxt     = drv_r;
    ack_sel_nxt = ack_sel_r;
    rx_nxt      = rx_r;
    fail_nxt    = fail_r;
    done        = 1'b0;

    if (ph_r == PH_IDLE) begin
      // Start a new command
      if (in_cmd) begin
        kind_nxt    = in_kind;
        bit_cnt_nxt = 4'd0;
        unique case (in_kind)
          i2c_mbs_pkg::KIND_START: begin
            drv_nxt = 1'b1;
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
            dly_nxt = dly_4us;
            ph_nxt  = PH_ST_A;
          end
          i2c_mbs_pkg::KIND_STOP: begin
            drv_nxt = 1'b1;
            scl_nxt = 1'b0;
            sda_nxt = 1'b0;
            dly_nxt = dly_4us;
            ph_nxt  = PH_SP_A;
          end
          i2c_mbs_pkg::KIND_WRITE: begin
            drv_nxt   = 1'b1;
            scl_nxt   = 1'b0;
            sda_nxt   = in_tx[BW-1];
            shift_nxt = {in_tx[BW-2:0], 1'b0};
            dly_nxt   = dly_2us;
            ph_nxt    = PH_WR_SETUP;
          end
          i2c_mbs_pkg::KIND_WAIT_ACK: begin
            drv_nxt  = 1'b0;
            sda_nxt  = 1'b1;
            fail_nxt = 1'b0;
            poll_nxt = '0;
            dly_nxt  = dly_1us;
            ph_nxt   = PH_WA_A;
          end
          i2c_mbs_pkg::KIND_READ_ACK, i2c_mbs_pkg::KIND_READ: begin
            ack_sel_nxt = in_ack;
            drv_nxt     = 1'b0;
            scl_nxt     = 1'b0;
            shift_nxt   = '0;
            dly_nxt     = dly_2us;
            ph_nxt      = PH_RD_LOW;
          end
          i2c_mbs_pkg::KIND_SEND_ACK, i2c_mbs_pkg::KIND_SEND_NAK: begin
            ack_sel_nxt = (in_kind == i2c_mbs_pkg::KIND_SEND_ACK);
            scl_nxt     = 1'b0;
            drv_nxt     = 1'b1;
            sda_nxt     = (in_kind != i2c_mbs_pkg::KIND_SEND_ACK);
            dly_nxt     = dly_2us;
            ph_nxt      = PH_AK_A;
          end
          default: ;
        endcase
      end
    end else if (ph_r == PH_WA_POLL) begin
      // Poll SDA for the acknowledge, with a timeout that sends a stop
      if (!in_sda) begin
        scl_nxt  = 1'b0;
        fail_nxt = 1'b0;
        done     = 1'b1;
      end else if (poll_r >= poll_lim_r) begin
        fail_nxt = 1'b1;
        drv_nxt  = 1'b1;
        scl_nxt  = 1'b0;
        sda_nxt  = 1'b0;
        dly_nxt  = dly_4us;
        ph_nxt   = PH_SP_A;
      end else begin
        poll_nxt = poll_r + CW'(1);
      end
    end else begin
      // Count down the line delay, then take the next step
      dly_nxt = dly_dec;
      if (dly_dec == '0) begin
        unique case (ph_r)
          PH_ST_A: begin
            sda_nxt = 1'b0;
            dly_nxt = dly_4us;
            ph_nxt  = PH_ST_B;
          end
          PH_ST_B: begin
            scl_nxt = 1'b0;
            done    = 1'b1;
          end
          PH_SP_A: begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b1;
            dly_nxt = dly_4us;
            ph_nxt  = PH_SP_B;
          end
          PH_WR_SETUP: begin
            scl_nxt = 1'b1;
            dly_nxt = dly_2us;
            ph_nxt  = PH_WR_HIGH;
          end
          PH_WR_HIGH: begin
            scl_nxt = 1'b0;
            dly_nxt = dly_2us;
            ph_nxt  = PH_WR_LOW;
          end
          PH_WR_LOW: begin
            bit_cnt_nxt = bit_cnt_inc;
            if (bit_cnt_inc >= 4'd8) begin
              done = 1'b1;
            end else begin
              sda_nxt   = shift_r[BW-1];
              shift_nxt = {shift_r[BW-2:0], 1'b0};
              dly_nxt   = dly_2us;
              ph_nxt    = PH_WR_SETUP;
            end
          end
          PH_WA_A: begin
            scl_nxt = 1'b1;
            dly_nxt = dly_1us;
            ph_nxt  = PH_WA_B;
          end
          PH_WA_B: begin
            poll_nxt = '0;
            ph_nxt   = PH_WA_POLL;
          end
          PH_RD_LOW: begin
            // Sample the data bit as SCL rises
            scl_nxt   = 1'b1;
            shift_nxt = {shift_r[BW-2:0], in_sda};
            dly_nxt   = dly_1us;
            ph_nxt    = PH_RD_HIGH;
          end
          PH_RD_HIGH: begin
            bit_cnt_nxt = bit_cnt_inc;
            if (bit_cnt_inc >= 4'd8) begin
              rx_nxt = shift_r;
              if (kind_r == i2c_mbs_pkg::KIND_READ_ACK) begin
                scl_nxt = 1'b0;
                drv_nxt = 1'b1;
                sda_nxt = !ack_sel_r;
                dly_nxt = dly_2us;
                ph_nxt  = PH_AK_A;
              end else begin
                done = 1'b1;
              end
            end else begin
              scl_nxt = 1'b0;
              dly_nxt = dly_2us;
              ph_nxt  = PH_RD_LOW;
            end
          end
          PH_AK_A: begin
            scl_nxt = 1'b1;
            dly_nxt = dly_2us;
            ph_nxt  = PH_AK_B;
          end
          PH_AK_B: begin
            scl_nxt = 1'b0;
            done    = 1'b1;
          end
          default: done = 1'b1;
        endcase
      end
    end

    if (done) begin
      ph_nxt = PH_IDLE;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r      <= i2c_mbs_pkg::TICKS_PER_US_RST;
      poll_lim_r <= i2c_mbs_pkg::ACK_POLL_LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == i2c_mbs_pkg::CFG_TICKS_PER_US) begin
        tpu_r <= cfg_data;
      end else if (cfg_index == i2c_mbs_pkg::CFG_ACK_POLL_LIM) begin
        poll_lim_r <= cfg_data;
      end
    end
  end

  // Sequencer state, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= PH_IDLE;
      kind_r    <= i2c_mbs_pkg::KIND_START;
      dly_r     <= '0;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      poll_r    <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      drv_r     <= 1'b1;
      ack_sel_r <= 1'b0;
      rx_r      <= '0;
      fail_r    <= 1'b0;
    end else if (in_fire) begin
      ph_r      <= ph_nxt;
      kind_r    <= kind_nxt;
      dly_r     <= dly_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      poll_r    <= poll_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      drv_r     <= drv_nxt;
      ack_sel_r <= ack_sel_nxt;
      rx_r      <= rx_nxt;
      fail_r    <= fail_nxt;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {2'b00, fail_nxt, rx_nxt, done, (ph_nxt != PH_IDLE), drv_nxt,
                     (drv_nxt ? sda_nxt : 1'b1), scl_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### sv/i2c_mbs_checker.sv
// Port-level checks for the I2C master bit sequencer core.
// Depends on i2c_mbs_pkg; bound to i2c_master_bit_sequencer_core below.

module i2c_mbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result word holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  // Input is taken whenever the result register can move on
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled while result register free");

  // A finishing command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[i2c_mbs_pkg::OUT_DONE] |-> !out_tdata[i2c_mbs_pkg::OUT_BUSY])
    else $error("done pulse while busy");

  // SDA reads released whenever the master does not drive it
  a_sda_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[i2c_mbs_pkg::OUT_DRV] |-> out_tdata[i2c_mbs_pkg::OUT_SDA])
    else $error("undriven SDA not released");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

endmodule

bind i2c_master_bit_sequencer_core i2c_mbs_checker u_i2c_mbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
